// ===== src/itbf_pkg.sv =====
package itbf_pkg;

  localparam int MAX_NAME_LEN = 16;
  localparam int NLEN_W = $clog2(MAX_NAME_LEN + 1);
  localparam int IDX_W = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int CPOS_W = $clog2(MAX_NAME_LEN + 3);
  localparam int QUEUE_DEPTH = 2;

  typedef logic [6:0] ascii_t;
  typedef logic [15:0] unit_t;

  localparam ascii_t CH_LT = 7'h3C;
  localparam ascii_t CH_GT = 7'h3E;
  localparam ascii_t CH_SLASH = 7'h2F;
  localparam ascii_t CH_SPACE = 7'h20;
  localparam ascii_t CH_TAB = 7'h09;
  localparam ascii_t CH_UNDERSCORE = 7'h5F;
  localparam ascii_t CH_COLON = 7'h3A;
  localparam ascii_t CH_COMMA = 7'h2C;
  localparam ascii_t CH_PERIOD = 7'h2E;
  localparam ascii_t CH_QUESTION = 7'h3F;
  localparam ascii_t CH_EXCLAIM = 7'h21;
  localparam ascii_t CH_TILDE = 7'h7E;

  localparam unit_t FW_COMMA = 16'hFF0C;
  localparam unit_t IDEO_STOP = 16'h3002;
  localparam unit_t FW_QUESTION = 16'hFF1F;
  localparam unit_t FW_EXCLAIM = 16'hFF01;
  localparam unit_t FW_COLON = 16'hFF1A;
  localparam unit_t FW_LPAREN = 16'hFF08;
  localparam unit_t FW_RPAREN = 16'hFF09;
  localparam unit_t LENT_OPEN = 16'h3010;
  localparam unit_t LENT_CLOSE = 16'h3011;
  localparam unit_t DANGLE_OPEN = 16'h300A;
  localparam unit_t DANGLE_CLOSE = 16'h300B;
  localparam unit_t FW_TILDE = 16'hFF5E;

  localparam unit_t SURR_LO = 16'hD800;
  localparam unit_t SURR_HI = 16'hDFFF;
  localparam unit_t TECH_LO = 16'h2300;
  localparam unit_t TECH_HI = 16'h23FF;
  localparam unit_t SYM_LO = 16'h2600;
  localparam unit_t SYM_HI = 16'h27BF;
  localparam unit_t ARROW_LO = 16'h2B00;
  localparam unit_t ARROW_HI = 16'h2BFF;

  localparam unit_t ZW_JOINER = 16'h200D;
  localparam unit_t VAR_SEL_15 = 16'hFE0E;
  localparam unit_t VAR_SEL_16 = 16'hFE0F;
  localparam unit_t KEYCAP = 16'h20E3;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_TRYING = 2'd1,
    MODE_INSIDE = 2'd2
  } mode_t;

  typedef struct packed {
    logic lt;
    logic gt;
    logic slash;
    logic space;
    logic letter;
    logic name_cont;
    logic punct_or_emoji;
    logic keep_gap;
  } ch_class_t;

  typedef struct packed {
    ascii_t    c7;
    logic      ascii;
    logic      sol;
    ch_class_t cls;
  } item_t;

endpackage

// ===== src/itbf_in_if.sv =====
interface itbf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] ch;
  logic        at_line_start;

  modport source (output valid, output ch, output at_line_start, input ready);
  modport sink (input valid, input ch, input at_line_start, output ready);
endinterface

// ===== src/itbf_out_if.sv =====
interface itbf_out_if;
  logic       valid;
  logic       ready;
  logic       keep_char;
  logic [1:0] mode;

  modport source (output valid, output keep_char, output mode, input ready);
  modport sink (input valid, input keep_char, input mode, output ready);
endinterface

// ===== src/itbf_front.sv =====
module itbf_front (
  input  logic            clk,
  input  logic            rst,
  itbf_in_if.sink         text,
  output logic            push_valid,
  output itbf_pkg::item_t push_item,
  input  logic            push_ready
);

  logic                 f_valid;
  itbf_pkg::item_t      f_item;
  itbf_pkg::item_t      cls_item;
  logic [15:0]          c;
  logic                 ascii;
  itbf_pkg::ascii_t     c7;
  logic                 is_letter;
  logic                 is_digit;
  logic                 is_punct;
  logic                 is_emoji;
  logic                 is_joiner;

  assign c = text.ch;
  assign ascii = (c[15:7] == 9'd0);
  assign c7 = c[6:0];

  always_comb begin
    is_letter = ascii && ((c7 >= 7'h41 && c7 <= 7'h5A) || (c7 >= 7'h61 && c7 <= 7'h7A));
    is_digit = ascii && (c7 >= 7'h30 && c7 <= 7'h39);
    is_punct = (c == itbf_pkg::FW_COMMA) || (c == itbf_pkg::IDEO_STOP) ||
               (c == itbf_pkg::FW_QUESTION) || (c == itbf_pkg::FW_EXCLAIM) ||
               (c == itbf_pkg::FW_COLON) || (c == itbf_pkg::FW_LPAREN) ||
               (c == itbf_pkg::FW_RPAREN) || (c == itbf_pkg::LENT_OPEN) ||
               (c == itbf_pkg::LENT_CLOSE) || (c == itbf_pkg::DANGLE_OPEN) ||
               (c == itbf_pkg::DANGLE_CLOSE) || (c == itbf_pkg::FW_TILDE) ||
               (ascii && ((c7 == itbf_pkg::CH_COLON) || (c7 == itbf_pkg::CH_COMMA) ||
                          (c7 == itbf_pkg::CH_PERIOD) || (c7 == itbf_pkg::CH_QUESTION) ||
                          (c7 == itbf_pkg::CH_EXCLAIM) || (c7 == itbf_pkg::CH_TILDE)));
    is_emoji = (c >= itbf_pkg::SURR_LO && c <= itbf_pkg::SURR_HI) ||
               (c >= itbf_pkg::TECH_LO && c <= itbf_pkg::TECH_HI) ||
               (c >= itbf_pkg::SYM_LO && c <= itbf_pkg::SYM_HI) ||
               (c >= itbf_pkg::ARROW_LO && c <= itbf_pkg::ARROW_HI);
    is_joiner = (c == itbf_pkg::ZW_JOINER) || (c == itbf_pkg::VAR_SEL_15) ||
                (c == itbf_pkg::VAR_SEL_16) || (c == itbf_pkg::KEYCAP);

    cls_item.c7 = c7;
    cls_item.ascii = ascii;
    cls_item.sol = text.at_line_start;
    cls_item.cls.lt = ascii && (c7 == itbf_pkg::CH_LT);
    cls_item.cls.gt = ascii && (c7 == itbf_pkg::CH_GT);
    cls_item.cls.slash = ascii && (c7 == itbf_pkg::CH_SLASH);
    cls_item.cls.space = ascii && (c7 == itbf_pkg::CH_SPACE);
    cls_item.cls.letter = is_letter;
    cls_item.cls.name_cont = is_letter || is_digit ||
                             (ascii && (c7 == itbf_pkg::CH_UNDERSCORE));
    cls_item.cls.punct_or_emoji = is_punct || is_emoji;
    cls_item.cls.keep_gap = (ascii && ((c7 == itbf_pkg::CH_SPACE) ||
                                       (c7 == itbf_pkg::CH_TAB))) || is_joiner;
  end

  assign text.ready = !f_valid || push_ready;
  assign push_valid = f_valid;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      f_item <= cls_item;
    end
  end

endmodule

// ===== src/itbf_queue.sv =====
module itbf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  itbf_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output itbf_pkg::item_t pop_item,
  input  logic            pop_ready
);

  localparam int PTR_W = (itbf_pkg::QUEUE_DEPTH > 1) ? $clog2(itbf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(itbf_pkg::QUEUE_DEPTH + 1);

  itbf_pkg::item_t  slots [itbf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(itbf_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = slots[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(itbf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(itbf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/itbf_back.sv =====
module itbf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            pop_valid,
  input  itbf_pkg::item_t pop_item,
  output logic            pop_ready,
  itbf_out_if.source      verdict
);

  localparam int NLEN_W = itbf_pkg::NLEN_W;
  localparam int IDX_W = itbf_pkg::IDX_W;
  localparam int CPOS_W = itbf_pkg::CPOS_W;

  typedef enum logic [1:0] {
    PH_WAIT_LT = 2'd0,
    PH_FIRST   = 2'd1,
    PH_NAME    = 2'd2,
    PH_ATTRS   = 2'd3
  } phase_t;

  logic                include_tags;
  itbf_pkg::mode_t     mode, mode_next;
  phase_t              phase, phase_next;
  logic [NLEN_W-1:0]   nlen, nlen_next;
  logic [CPOS_W-1:0]   cpos, cpos_next;
  logic                armed, armed_next;
  logic                aac, aac_next;
  logic                aap, aap_next;
  logic                prev_slash;
  logic                out_valid;
  logic                out_keep;
  itbf_pkg::mode_t     out_mode;
  logic                keep_next;

  itbf_pkg::ascii_t    name_store [itbf_pkg::MAX_NAME_LEN];
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;

  logic                step;
  logic [CPOS_W-1:0]   idx;
  itbf_pkg::ascii_t    pattern;
  logic                hit;
  logic [CPOS_W:0]     cpos_inc;
  logic [CPOS_W:0]     nlen_plus3;
  logic                fire;
  logic                do_clear;
  itbf_pkg::mode_t     mode_was;

  assign step = pop_valid && (!out_valid || verdict.ready);
  assign pop_ready = !out_valid || verdict.ready;

  assign verdict.valid = out_valid;
  assign verdict.keep_char = out_keep;
  assign verdict.mode = out_mode;

  // closing pattern lookup
  always_comb begin
    idx = cpos - CPOS_W'(2);
    if (cpos == CPOS_W'(0)) begin
      pattern = itbf_pkg::CH_LT;
    end else if (cpos == CPOS_W'(1)) begin
      pattern = itbf_pkg::CH_SLASH;
    end else if (idx < CPOS_W'(nlen)) begin
      pattern = name_store[idx[IDX_W-1:0]];
    end else begin
      pattern = itbf_pkg::CH_GT;
    end
    hit = pop_item.ascii && (pop_item.c7 == pattern);
    cpos_inc = {1'b0, cpos} + 1'b1;
    nlen_plus3 = (CPOS_W + 1)'(nlen) + (CPOS_W + 1)'(3);
  end

  always_comb begin
    mode_next = mode;
    phase_next = phase;
    nlen_next = nlen;
    cpos_next = cpos;
    armed_next = armed;
    aac_next = aac;
    aap_next = aap;
    keep_next = 1'b1;
    wr_en = 1'b0;
    wr_addr = nlen[IDX_W-1:0];
    fire = 1'b0;
    do_clear = 1'b0;
    mode_was = mode;

    if (mode == itbf_pkg::MODE_INSIDE) begin
      if (armed) begin
        if (hit) begin
          if (cpos_inc >= nlen_plus3) begin
            aac_next = 1'b1;
            aap_next = 1'b0;
            do_clear = 1'b1;
          end else begin
            cpos_next = cpos_inc[CPOS_W-1:0];
          end
        end else begin
          cpos_next = pop_item.cls.lt ? CPOS_W'(1) : CPOS_W'(0);
        end
      end
      keep_next = include_tags;
    end else if (mode == itbf_pkg::MODE_IDLE && !pop_item.sol &&
                 (!(aac || aap) || pop_item.cls.keep_gap)) begin
      if (pop_item.cls.punct_or_emoji) begin
        aap_next = 1'b1;
      end else if (!pop_item.cls.keep_gap) begin
        aap_next = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_WAIT_LT: begin
          if (pop_item.cls.lt) begin
            nlen_next = '0;
            phase_next = PH_FIRST;
            mode_next = itbf_pkg::MODE_TRYING;
          end
        end
        PH_FIRST: begin
          if (pop_item.cls.letter) begin
            wr_en = 1'b1;
            wr_addr = '0;
            nlen_next = NLEN_W'(1);
            phase_next = PH_NAME;
            mode_next = itbf_pkg::MODE_TRYING;
          end else begin
            phase_next = PH_WAIT_LT;
            mode_next = itbf_pkg::MODE_IDLE;
            nlen_next = '0;
          end
        end
        PH_NAME: begin
          if (pop_item.cls.space) begin
            phase_next = PH_ATTRS;
            mode_next = itbf_pkg::MODE_TRYING;
          end else if (pop_item.cls.gt) begin
            phase_next = PH_WAIT_LT;
            mode_next = itbf_pkg::MODE_TRYING;
            fire = 1'b1;
          end else if (!pop_item.cls.name_cont ||
                       nlen >= NLEN_W'(itbf_pkg::MAX_NAME_LEN)) begin
            phase_next = PH_WAIT_LT;
            mode_next = itbf_pkg::MODE_IDLE;
            nlen_next = '0;
          end else begin
            wr_en = 1'b1;
            nlen_next = nlen + 1'b1;
            mode_next = itbf_pkg::MODE_TRYING;
          end
        end
        PH_ATTRS: begin
          mode_next = itbf_pkg::MODE_TRYING;
          if (pop_item.cls.gt) begin
            phase_next = PH_WAIT_LT;
            fire = 1'b1;
          end
        end
      endcase

      if (fire) begin
        if (prev_slash) begin
          do_clear = 1'b1;
        end else begin
          mode_next = itbf_pkg::MODE_INSIDE;
          aac_next = 1'b0;
          aap_next = 1'b0;
          armed_next = 1'b1;
          cpos_next = '0;
          phase_next = PH_WAIT_LT;
          keep_next = include_tags;
        end
      end else if (mode_next == itbf_pkg::MODE_TRYING) begin
        aap_next = 1'b0;
        keep_next = include_tags;
      end else begin
        if (mode_was == itbf_pkg::MODE_TRYING) begin
          do_clear = 1'b1;
        end
        aac_next = 1'b0;
        aap_next = pop_item.cls.punct_or_emoji;
      end
    end

    if (do_clear) begin
      mode_next = itbf_pkg::MODE_IDLE;
      phase_next = PH_WAIT_LT;
      nlen_next = '0;
      cpos_next = '0;
      armed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      include_tags <= 1'b0;
      mode <= itbf_pkg::MODE_IDLE;
      phase <= PH_WAIT_LT;
      nlen <= '0;
      cpos <= '0;
      armed <= 1'b0;
      aac <= 1'b0;
      aap <= 1'b0;
      prev_slash <= 1'b0;
      out_valid <= 1'b0;
      out_keep <= 1'b0;
      out_mode <= itbf_pkg::MODE_IDLE;
    end else begin
      if (cfg_we) begin
        include_tags <= cfg_wdata;
      end
      if (step) begin
        mode <= mode_next;
        phase <= phase_next;
        nlen <= nlen_next;
        cpos <= cpos_next;
        armed <= armed_next;
        aac <= aac_next;
        aap <= aap_next;
        prev_slash <= pop_item.cls.slash;
        out_valid <= 1'b1;
        out_keep <= keep_next;
        out_mode <= mode_next;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // tag name buffer
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      name_store[wr_addr] <= pop_item.c7;
    end
  end

`ifndef SYNTHESIS
  a_name_len: assert property (@(posedge clk) disable iff (rst)
    nlen <= NLEN_W'(itbf_pkg::MAX_NAME_LEN))
    else $error("tag name length past buffer");

  a_armed_inside: assert property (@(posedge clk) disable iff (rst)
    armed == (mode == itbf_pkg::MODE_INSIDE))
    else $error("close matcher armed out of step with mode");

  a_trying_phase: assert property (@(posedge clk) disable iff (rst)
    (mode == itbf_pkg::MODE_TRYING) |-> (phase != PH_WAIT_LT))
    else $error("trying a tag while waiting for less-than");

  a_close_pos: assert property (@(posedge clk) disable iff (rst)
    (mode == itbf_pkg::MODE_INSIDE) |-> ({1'b0, cpos} < nlen_plus3))
    else $error("close match position past pattern end");
`endif

endmodule

// ===== src/inline_tag_block_filter.sv =====
// channel   dir  payload                      handshake
// text      in   ch[15:0], at_line_start      valid/ready
// verdict   out  keep_char, mode[1:0]         valid/ready
// cfg       in   cfg_wdata (include_tags)     cfg_we, no wait
//
// one item per cycle sustained while verdict is ready; text accept to verdict valid passes
// through the classify register, two-entry queue and result register
// each item does one compare against one closing pattern character (<, /, stored name, >) in the back end
// rst is synchronous and clears all control state; the name buffer is not cleared
// a stalled verdict holds the back end; the queue and front register absorb three items

module inline_tag_block_filter (
  input  logic       clk,
  input  logic       rst,
  itbf_in_if.sink    text,
  itbf_out_if.source verdict,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic            push_valid;
  logic            push_ready;
  itbf_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  itbf_pkg::item_t pop_item;

  itbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  itbf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  itbf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .verdict   (verdict)
  );

endmodule
